### rtl/core/izn_pkg.sv
// izn_pkg: shared types, constants and helpers of the imu window z-score normalizer
// no dependencies; imported by every module of the block
package izn_pkg;

    localparam int DEF_WINDOW_DEPTH = 32;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int AXIS_COUNT       = 6;
    localparam int FIELD_W          = 16;
    localparam int POS_W            = 6;
    localparam int STRIDE_W         = 7;
    localparam int FRAC_BITS        = 13;
    localparam int DIV_STEPS        = 18;
    localparam int APB_AW           = 3;
    localparam int APB_DW           = 32;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd16;
    localparam logic [STRIDE_W-1:0] STRIDE_MAX   = 7'd64;
    localparam logic [STRIDE_W-1:0] STRIDE_MIN   = 7'd1;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_STRIDE = 1'b0;

    typedef struct packed {
        logic                      mode;
        logic signed [FIELD_W-1:0] accel_x;
        logic signed [FIELD_W-1:0] accel_y;
        logic signed [FIELD_W-1:0] accel_z;
        logic signed [FIELD_W-1:0] gyro_x;
        logic signed [FIELD_W-1:0] gyro_y;
        logic signed [FIELD_W-1:0] gyro_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] norm_accel_x;
        logic signed [FIELD_W-1:0] norm_accel_y;
        logic signed [FIELD_W-1:0] norm_accel_z;
        logic signed [FIELD_W-1:0] norm_gyro_x;
        logic signed [FIELD_W-1:0] norm_gyro_y;
        logic signed [FIELD_W-1:0] norm_gyro_z;
        logic [POS_W-1:0]          sample_position;
        logic                      last;
    } out_beat_t;

    typedef struct packed {
        logic clr;
        logic acc;
        logic vmul;
        logic vsub;
        logic sq_step;
        logic div_load;
        logic div_step;
    } lane_ctrl_t;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_ACC  = 9'b000000010,
        ST_VMUL = 9'b000000100,
        ST_VSUB = 9'b000001000,
        ST_SQRT = 9'b000010000,
        ST_RD   = 9'b000100000,
        ST_LD   = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_EMIT = 9'b100000000
    } state_t;

    // number of two-bit steps of the square root for a given window and sample width
    function automatic int izn_sqrt_steps(int depth, int sb);
        int aw;
        int radw;
        aw   = $clog2(depth + 1);
        radw = 2 * sb + 2 * aw + 4;
        return (radw + 1) / 2;
    endfunction

endpackage

### rtl/core/izn_lane.sv
// izn_lane: per-axis core, window sums, variance, bit-pair square root, serial divider
// depends on izn_pkg
module izn_lane #(
    parameter int WINDOW_DEPTH = izn_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = izn_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              aclk,
    input  izn_pkg::lane_ctrl_t               ctrl,
    input  logic signed [SAMPLE_BITS-1:0]     x,
    output logic [izn_pkg::FIELD_W-1:0]       z
);
    import izn_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SW   = SAMPLE_BITS + AW;
    localparam int QW   = 2 * SAMPLE_BITS + AW;
    localparam int VW   = 2 * SW;
    localparam int SQS  = izn_sqrt_steps(WINDOW_DEPTH, SAMPLE_BITS);
    localparam int RADW = 2 * SQS;
    localparam int RTW  = SQS;
    localparam int DMW  = SAMPLE_BITS + AW + 1;
    localparam int NUMW = DMW + FRAC_BITS + 1;
    localparam int DW   = (NUMW > RTW + DIV_STEPS) ? NUMW : RTW + DIV_STEPS;

    localparam logic [VW-1:0]       NN_FLOOR = VW'(WINDOW_DEPTH * WINDOW_DEPTH);
    localparam logic signed [DMW:0] N_S      = (DMW + 1)'(WINDOW_DEPTH);
    localparam logic [DIV_STEPS-2:0] POS_LIM = (DIV_STEPS - 1)'(32767);
    localparam logic [DIV_STEPS-2:0] NEG_LIM = (DIV_STEPS - 1)'(32768);

    logic signed [SW-1:0]        sum_reg, sum_next;
    logic [QW-1:0]               sq_reg, sq_next;
    logic [VW-1:0]               nq_reg, ss_reg;
    logic [RADW-1:0]             rad_reg, rad_next;
    logic [RTW-1:0]              root_reg, root_next;
    logic [RTW+1:0]              rem_reg, rem_next;
    logic [DW-1:0]               drem_reg, drem_next;
    logic [DW-1:0]               dv_reg, dv_next;
    logic [DIV_STEPS-1:0]        q_reg, q_next;
    logic                        neg_reg, neg_next;

    logic signed [2*SAMPLE_BITS-1:0] xx;
    logic signed [VW-1:0]            s_sq;
    logic [VW-1:0]                   var_raw, var_fl;
    logic [RTW+3:0]                  sq_tmp, sq_trial;
    logic signed [DMW:0]             d;
    logic [DMW-1:0]                  dm;
    logic [DIV_STEPS-2:0]            mag;

    assign xx   = x * x;
    assign s_sq = sum_reg * sum_reg;
    assign var_raw = nq_reg - ss_reg;
    assign var_fl  = (var_raw < NN_FLOOR) ? NN_FLOOR : var_raw;
    assign sq_tmp   = {rem_reg, rad_reg[RADW-1 -: 2]};
    assign sq_trial = (RTW + 4)'({root_reg, 2'b01});
    assign d  = (DMW + 1)'(x) * N_S - (DMW + 1)'(sum_reg);
    assign dm = d[DMW] ? DMW'(-d) : DMW'(d);

    always_comb begin
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        drem_next = drem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        if (ctrl.clr) begin
            sum_next = '0;
            sq_next  = '0;
        end
        if (ctrl.acc) begin
            sum_next = sum_reg + SW'(x);
            sq_next  = sq_reg + QW'($unsigned(xx));
        end
        if (ctrl.vsub) begin
            rad_next  = RADW'({var_fl, 4'b0000});
            root_next = '0;
            rem_next  = '0;
        end
        if (ctrl.sq_step) begin
            rad_next = rad_reg << 2;
            if (sq_tmp >= sq_trial) begin
                rem_next  = (RTW + 2)'(sq_tmp - sq_trial);
                root_next = {root_reg[RTW-2:0], 1'b1};
            end else begin
                rem_next  = (RTW + 2)'(sq_tmp);
                root_next = {root_reg[RTW-2:0], 1'b0};
            end
        end
        if (ctrl.div_load) begin
            drem_next = (DW'(dm) << FRAC_BITS) + DW'(root_reg >> 1);
            dv_next   = DW'(root_reg) << (DIV_STEPS - 1);
            q_next    = '0;
            neg_next  = d[DMW];
        end
        if (ctrl.div_step) begin
            dv_next = dv_reg >> 1;
            if (drem_reg >= dv_reg) begin
                drem_next = drem_reg - dv_reg;
                q_next    = {q_reg[DIV_STEPS-2:0], 1'b1};
            end else begin
                q_next    = {q_reg[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        sq_reg   <= sq_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        drem_reg <= drem_next;
        dv_reg   <= dv_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        if (ctrl.vmul) begin
            nq_reg <= VW'(sq_reg) * VW'(WINDOW_DEPTH);
            ss_reg <= VW'($unsigned(s_sq));
        end
    end

    // saturate the quotient, top bit flags an overflowing quotient
    assign mag = q_reg[DIV_STEPS-2:0];
    always_comb begin
        if (neg_reg) begin
            if (q_reg[DIV_STEPS-1] || mag > NEG_LIM) z = 16'h8000;
            else z = FIELD_W'(-mag);
        end else begin
            if (q_reg[DIV_STEPS-1] || mag > POS_LIM) z = 16'h7fff;
            else z = FIELD_W'(mag);
        end
    end

endmodule

### rtl/core/izn_merge.sv
// izn_merge: gathers the lane z-scores into one result beat and holds it in the output register
// depends on izn_pkg
module izn_merge (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             load,
    input  logic [izn_pkg::AXIS_COUNT-1:0][izn_pkg::FIELD_W-1:0] z_vec,
    input  logic [izn_pkg::POS_W-1:0]                        pos,
    input  logic                                             last,
    output logic                                             free,
    output logic                                             m_valid,
    input  logic                                             m_ready,
    output izn_pkg::out_beat_t                               m_data
);
    import izn_pkg::*;

    out_beat_t beat_reg, beat_next;
    logic      vld_reg, vld_next;

    assign free = !vld_reg || m_ready;

    always_comb begin
        beat_next.norm_accel_x    = z_vec[0];
        beat_next.norm_accel_y    = z_vec[1];
        beat_next.norm_accel_z    = z_vec[2];
        beat_next.norm_gyro_x     = z_vec[3];
        beat_next.norm_gyro_y     = z_vec[4];
        beat_next.norm_gyro_z     = z_vec[5];
        beat_next.sample_position = pos;
        beat_next.last            = last;
        vld_next = vld_reg;
        if (m_ready) vld_next = 1'b0;
        if (load) vld_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (load) beat_reg <= beat_next;
    end

    assign m_valid = vld_reg;
    assign m_data  = beat_reg;

endmodule

### rtl/core/imu_window_zscore_normalizer_top.sv
// a triggering sample starts a pass: window sums, variance, square root (SQS = root steps, 24
// at the defaults), then per window position, oldest first, a division and a result beat
// that stalls while m_ready is low; other input beats are taken whenever the block is idle
// throughput: sum pass, bit-pair root and serial divider per sample on six lanes; no
// input is taken during a pass
// reset: sync active-low; clears pointers, counts, pending flag, valid; stride to 16; ring kept
module imu_window_zscore_normalizer_top #(
    parameter int WINDOW_DEPTH = izn_pkg::DEF_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = izn_pkg::DEF_SAMPLE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  izn_pkg::in_beat_t           s_data,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output izn_pkg::out_beat_t          m_data,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [izn_pkg::APB_AW-1:0]  paddr,
    input  logic [izn_pkg::APB_DW-1:0]  pwdata,
    output logic [izn_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import izn_pkg::*;

    localparam int AW   = $clog2(WINDOW_DEPTH + 1);
    localparam int PW   = $clog2(WINDOW_DEPTH);
    localparam int SQS  = izn_sqrt_steps(WINDOW_DEPTH, SAMPLE_BITS);
    localparam int MX1  = (SQS > DIV_STEPS) ? SQS : DIV_STEPS;
    localparam int MXS  = (MX1 > WINDOW_DEPTH) ? MX1 : WINDOW_DEPTH;
    localparam int STW  = $clog2(MXS + 1);
    localparam int RW   = AXIS_COUNT * SAMPLE_BITS;

    // ---------------- configuration ----------------
    logic [STRIDE_W-1:0] stride_reg;
    logic                cfg_wr;
    logic [STRIDE_W-1:0] eff_stride;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STRIDE);
    assign prdata = (paddr[2] == REG_STRIDE) ? APB_DW'(stride_reg) : '0;

    // zero acts as one, anything above 64 acts as 64
    always_comb begin
        if (stride_reg < STRIDE_MIN) eff_stride = STRIDE_MIN;
        else if (stride_reg > STRIDE_MAX) eff_stride = STRIDE_MAX;
        else eff_stride = stride_reg;
    end

    // ---------------- sequencer state ----------------
    state_t          state_reg, state_next;
    logic [STW-1:0]  stp_reg, stp_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [PW-1:0]   wp_reg, wp_next;
    logic [AW-1:0]   fill_reg, fill_next;
    logic [STRIDE_W-1:0] phase_reg, phase_next;
    logic            pend_reg, pend_next;

    logic s_fire, smp_fire, rel_fire, trig, start;
    logic [STRIDE_W-1:0] phase_inc;
    logic            merge_free, merge_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign smp_fire = s_fire && (s_data.mode == MODE_SAMPLE);
    assign rel_fire = s_fire && (s_data.mode == MODE_RELEASE);
    assign phase_inc = phase_reg + STRIDE_W'(1);

    // first trigger when the ring fills, then every effective stride samples
    assign trig  = (fill_reg < AW'(WINDOW_DEPTH)) ? (fill_reg == AW'(WINDOW_DEPTH - 1))
                                                  : (phase_inc >= eff_stride);
    assign start = smp_fire && trig && !pend_reg;

    always_comb begin
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        if (rel_fire) pend_next = 1'b0;
        if (smp_fire) begin
            wp_next = (wp_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            if (fill_reg < AW'(WINDOW_DEPTH)) fill_next = fill_reg + AW'(1);
            else phase_next = phase_inc;
            if (trig) phase_next = '0;
            if (start) pend_next = 1'b1;
        end
    end

    // ---------------- sample ring ----------------
    logic [RW-1:0]   ring_mem [WINDOW_DEPTH];
    logic [RW-1:0]   wr_word;
    logic [RW-1:0]   rd_data_reg;
    logic [PW-1:0]   rd_off;
    logic [PW:0]     rd_sum;
    logic [PW-1:0]   rd_addr;
    logic [AXIS_COUNT-1:0][FIELD_W-1:0] in_axis;

    assign in_axis[0] = s_data.accel_x;
    assign in_axis[1] = s_data.accel_y;
    assign in_axis[2] = s_data.accel_z;
    assign in_axis[3] = s_data.gyro_x;
    assign in_axis[4] = s_data.gyro_y;
    assign in_axis[5] = s_data.gyro_z;

    // narrow samples keep their low bits, wide ones sign-extend the field
    for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_take
        if (SAMPLE_BITS <= FIELD_W) begin : g_narrow
            assign wr_word[a*SAMPLE_BITS +: SAMPLE_BITS] = in_axis[a][SAMPLE_BITS-1:0];
        end else begin : g_wide
            assign wr_word[a*SAMPLE_BITS +: SAMPLE_BITS] =
                SAMPLE_BITS'($signed(in_axis[a]));
        end
    end

    // reads walk oldest first, starting at the write pointer
    assign rd_off  = (state_reg == ST_ACC) ? stp_reg[PW-1:0] : k_reg[PW-1:0];
    assign rd_sum  = {1'b0, wp_reg} + {1'b0, rd_off};
    assign rd_addr = (rd_sum >= (PW + 1)'(WINDOW_DEPTH))
                   ? PW'(rd_sum - (PW + 1)'(WINDOW_DEPTH)) : rd_sum[PW-1:0];

    always_ff @(posedge aclk) begin
        if (smp_fire) ring_mem[wp_reg] <= wr_word;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= ring_mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    lane_ctrl_t lane_ctrl;

    always_comb begin
        lane_ctrl.clr      = start;
        lane_ctrl.acc      = (state_reg == ST_ACC) && (stp_reg != '0);
        lane_ctrl.vmul     = (state_reg == ST_VMUL);
        lane_ctrl.vsub     = (state_reg == ST_VSUB);
        lane_ctrl.sq_step  = (state_reg == ST_SQRT);
        lane_ctrl.div_load = (state_reg == ST_LD);
        lane_ctrl.div_step = (state_reg == ST_DIV);
    end

    assign merge_load = (state_reg == ST_EMIT) && merge_free;

    always_comb begin
        state_next = state_reg;
        stp_next   = stp_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_ACC;
                    stp_next   = '0;
                end
            end
            ST_ACC: begin
                // the step past the last read only drains the registered read
                if (stp_reg == STW'(WINDOW_DEPTH)) state_next = ST_VMUL;
                else stp_next = stp_reg + STW'(1);
            end
            ST_VMUL: state_next = ST_VSUB;
            ST_VSUB: begin
                state_next = ST_SQRT;
                stp_next   = '0;
            end
            ST_SQRT: begin
                if (stp_reg == STW'(SQS - 1)) begin
                    state_next = ST_RD;
                    k_next     = '0;
                end else begin
                    stp_next = stp_reg + STW'(1);
                end
            end
            ST_RD: state_next = ST_LD;
            ST_LD: begin
                state_next = ST_DIV;
                stp_next   = '0;
            end
            ST_DIV: begin
                if (stp_reg == STW'(DIV_STEPS - 1)) state_next = ST_EMIT;
                else stp_next = stp_reg + STW'(1);
            end
            ST_EMIT: begin
                if (merge_free) begin
                    if (k_reg == AW'(WINDOW_DEPTH - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                        k_next     = k_reg + AW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            stp_reg    <= '0;
            k_reg      <= '0;
            wp_reg     <= '0;
            fill_reg   <= '0;
            phase_reg  <= '0;
            pend_reg   <= 1'b0;
            stride_reg <= STRIDE_RESET;
        end else begin
            state_reg <= state_next;
            stp_reg   <= stp_next;
            k_reg     <= k_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            if (cfg_wr) stride_reg <= pwdata[STRIDE_W-1:0];
        end
    end

    // ---------------- axis lanes ----------------
    logic [AXIS_COUNT-1:0][FIELD_W-1:0] lane_z;

    for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_lane
        izn_lane #(
            .WINDOW_DEPTH (WINDOW_DEPTH),
            .SAMPLE_BITS  (SAMPLE_BITS)
        ) u_lane (
            .aclk (aclk),
            .ctrl (lane_ctrl),
            .x    ($signed(rd_data_reg[a*SAMPLE_BITS +: SAMPLE_BITS])),
            .z    (lane_z[a])
        );
    end

    // ---------------- merge and output register ----------------
    izn_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (merge_load),
        .z_vec   (lane_z),
        .pos     (POS_W'(k_reg)),
        .last    (k_reg == AW'(WINDOW_DEPTH - 1)),
        .free    (merge_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### rtl/core/izn_checker.sv
// izn_checker: port-level assertions for the imu window z-score normalizer, bound to the top
// depends on izn_pkg and imu_window_zscore_normalizer_top
module izn_checker #(
    parameter int WINDOW_DEPTH = izn_pkg::DEF_WINDOW_DEPTH
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input izn_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input izn_pkg::out_beat_t m_data
);
    import izn_pkg::*;

    // stalled input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed while stalled");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // the last marker sits on the newest window position
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> m_data.sample_position == POS_W'(WINDOW_DEPTH - 1))
        else $error("last marker on wrong position");

    // mid-window the block takes no input
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("input accepted during window emission");

    // reset clears the result channel
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind imu_window_zscore_normalizer_top izn_checker #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
) u_izn_checker (.*);
